[src/tty_text_console_writer_defines.svh]
// Assertion macros shared by the console writer checker.
// Depends on nothing; include by bare file name.
`ifndef TTY_TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TTY_TEXT_CONSOLE_WRITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TTCW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tty console writer check failed");

// Next-cycle implication, disabled during reset.
`define TTCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tty console writer check failed");

`endif

[src/ttcw_pkg.sv]
// Shared types and constants of the text console writer.
// No dependencies; used by the cell store, the top level and the checker.
`timescale 1ns / 1ps

package ttcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [2:0] TAB_MASK       = 3'd7;

  localparam logic [3:0] RESET_FG = 4'hF;
  localparam logic [3:0] RESET_BG = 4'h1;
  localparam logic [15:0] RESET_BLANK = {RESET_BG, RESET_FG, CHAR_SPACE};

  localparam logic [0:0] REG_FG_COLOR = 1'b0;
  localparam logic [0:0] REG_BG_COLOR = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE_CHAR = 2'd0,
    OP_MOVE_TO    = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ_CELL  = 2'd3
  } op_t;

  // Block command to the cell store: scroll up one row, or fill every cell.
  typedef struct packed {
    logic        start;
    logic        scroll;
    logic [15:0] fill_cell;
  } ttcw_cmd_t;

endpackage

[src/ttcw_store.sv]
// Screen cell store: one synchronous memory plus its scroll and fill engine.
// Depends on ttcw_pkg; instantiated by tty_text_console_writer.
`timescale 1ns / 1ps

module ttcw_store import ttcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  localparam int CELLS  = COLUMNS * ROWS,
  localparam int AW     = $clog2(CELLS)
) (
  input  logic          clk,
  input  logic          rst,
  input  ttcw_cmd_t     cmd,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  output logic          busy
);

  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_COPY = 3'b010,
    P_FILL = 3'b100
  } phase_t;

  localparam logic [AW-1:0] LAST_COPY  = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] FIRST_BOT  = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLUMNS);

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_q;
  phase_t        phase;
  logic [AW-1:0] cnt;
  logic          copy_vld;
  logic [AW-1:0] copy_addr;
  logic [15:0]   fill_cell;

  logic          mem_we;
  logic [AW-1:0] mem_wr_addr;
  logic [15:0]   mem_wr_data;
  logic [AW-1:0] mem_rd_addr;

  // Reset starts a full fill with the reset blank.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= P_FILL;
      cnt       <= '0;
      copy_vld  <= 1'b0;
      fill_cell <= RESET_BLANK;
    end else begin
      // a copy read this cycle is written back next cycle
      copy_vld <= (phase == P_COPY);
      unique case (phase)
        P_IDLE: begin
          if (cmd.start) begin
            fill_cell <= cmd.fill_cell;
            cnt       <= '0;
            phase     <= cmd.scroll ? P_COPY : P_FILL;
          end
        end
        P_COPY: begin
          copy_addr <= cnt;
          if (cnt == LAST_COPY) begin
            phase <= P_FILL;
            cnt   <= FIRST_BOT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        P_FILL: begin
          // yield the write port to the last pending copy
          if (!copy_vld) begin
            if (cnt == LAST_CELL) begin
              phase <= P_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = wr_addr;
    mem_wr_data = wr_data;
    priority if (copy_vld) begin
      mem_we      = 1'b1;
      mem_wr_addr = copy_addr;
      mem_wr_data = rd_q;
    end else if (phase == P_FILL) begin
      mem_we      = 1'b1;
      mem_wr_addr = cnt;
      mem_wr_data = fill_cell;
    end else if (phase == P_IDLE) begin
      mem_we = wr_en;
    end else begin
      mem_we = 1'b0;
    end
    mem_rd_addr = (phase == P_COPY) ? cnt + ROW_STRIDE : rd_addr;
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[mem_rd_addr];
    if (mem_we) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  assign rd_data = rd_q;
  assign busy    = (phase != P_IDLE) || copy_vld;

endmodule

[src/tty_text_console_writer.sv]
// Text console writer: a character cell screen with a TTY-style cursor.
// An input word carries write_char, move_to, clear or read_cell; every word
// returns one result word with the linear cursor location, plus the cell
// contents for read_cell. Cells live in one synchronous memory in ttcw_store.
// Sequence per word: an accepted word is executed in S_EXEC and its result
// word is loaded in S_DONE once the output register is free, with S_READ
// between them for read_cell. The next word is taken after the result is
// loaded. A tab writes spaces in S_TAB up to the next tab stop. A clear
// fills every cell; a scroll (newline or wrap on the last row) copies every
// row up and blanks the bottom row through the single memory port pair; the
// sequencer waits in S_WAIT for either. After reset the store is filled with
// the reset blank and s_tready stays low until then; configuration writes
// are taken throughout.
// Depends on ttcw_pkg and ttcw_store.
`timescale 1ns / 1ps

module tty_text_console_writer import ttcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: index 0 fg_color, index 1 bg_color
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // operation[1:0], char_code[9:2], col[16:10], row[21:17], zero pad
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // cursor_location[10:0], cell_char[18:11], cell_attr[26:19], zero pad
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_TAB  = 6'b000100,
    S_WAIT = 6'b001000,
    S_READ = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t        state;

  // color registers
  logic [3:0]    fg_color;
  logic [3:0]    bg_color;
  logic [7:0]    attr;

  // held input word, coordinates already saturated
  op_t           item_op;
  logic [7:0]    item_char;
  logic [CW-1:0] item_col;
  logic [RW-1:0] item_row;

  // unpacked input fields
  logic [1:0]    in_op;
  logic [7:0]    in_char;
  logic [6:0]    in_col;
  logic [4:0]    in_row;
  logic [CW-1:0] in_col_sat;
  logic [RW-1:0] in_row_sat;

  // cursor
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [AW-1:0] cur_addr;
  logic [AW-1:0] item_addr;
  logic [AW+10:0] loc_wide;

  // pending cell fields of the result
  logic [7:0]    res_char;
  logic [7:0]    res_attr;

  // output register
  logic [10:0]   out_loc;
  logic [7:0]    out_char;
  logic [7:0]    out_attr;

  // store interface
  ttcw_cmd_t     cmd;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [15:0]   mem_wr_data;
  logic [15:0]   mem_rd_data;
  logic          store_busy;

  // cursor step decode
  logic          put_en;
  logic [7:0]    put_char;
  logic          put_wrap;
  logic          put_scroll;
  logic          bs_en;
  logic          nl_en;
  logic          clr_en;

  assign attr = {bg_color, fg_color};

  // Unpack and saturate the incoming word.
  assign in_op   = s_tdata[1:0];
  assign in_char = s_tdata[9:2];
  assign in_col  = s_tdata[16:10];
  assign in_row  = s_tdata[21:17];
  assign in_col_sat = (int'(in_col) > COLUMNS - 1) ? LAST_COL : CW'(in_col);
  assign in_row_sat = (int'(in_row) > ROWS - 1) ? LAST_ROW : RW'(in_row);

  // Linear cell addresses: one constant multiply and an add each.
  assign cur_addr  = AW'(AW'(cur_row) * AW'(COLUMNS)) + AW'(cur_col);
  assign item_addr = AW'(AW'(item_row) * AW'(COLUMNS)) + AW'(item_col);
  assign loc_wide  = (AW + 11)'(cur_addr);

  assign s_tready = (state == S_IDLE) && !store_busy;

  // Decide what the cursor and the store do this cycle.
  always_comb begin
    put_en   = 1'b0;
    put_char = item_char;
    bs_en    = 1'b0;
    nl_en    = 1'b0;
    clr_en   = 1'b0;
    if (state == S_EXEC) begin
      unique case (item_op)
        OP_WRITE_CHAR: begin
          priority if (item_char == CHAR_NEWLINE) begin
            nl_en = 1'b1;
          end else if (item_char == CHAR_TAB) begin
            put_en = 1'b0;
          end else if (item_char == CHAR_BACKSPACE) begin
            bs_en = (cur_col != '0);
          end else begin
            put_en = 1'b1;
          end
        end
        OP_CLEAR:    clr_en = 1'b1;
        OP_MOVE_TO,
        OP_READ_CELL: clr_en = 1'b0;
        default:     clr_en = 1'b0;
      endcase
    end else if (state == S_TAB) begin
      // pad with spaces up to the next tab stop
      put_en   = ((cur_col[2:0] & TAB_MASK) != 3'd0);
      put_char = CHAR_SPACE;
    end
    put_wrap   = (cur_col == LAST_COL);
    put_scroll = put_wrap && (cur_row == LAST_ROW);

    mem_wr_en   = put_en || bs_en;
    mem_wr_addr = bs_en ? cur_addr - 1'b1 : cur_addr;
    mem_wr_data = {attr, bs_en ? CHAR_SPACE : put_char};

    cmd.start     = clr_en || (put_en && put_scroll) || (nl_en && cur_row == LAST_ROW);
    cmd.scroll    = !clr_en;
    cmd.fill_cell = {attr, CHAR_SPACE};
  end

  // Color registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= RESET_FG;
      bg_color <= RESET_BG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FG_COLOR: fg_color <= cfg_data;
        REG_BG_COLOR: bg_color <= cfg_data;
        default:      fg_color <= fg_color;
      endcase
    end
  end

  // Sequencer, cursor and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur_col  <= '0;
      cur_row  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop valid once drained, unless a new result is loaded right now
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end

      // cursor moves driven by the step decode
      if (put_en) begin
        if (put_wrap) begin
          cur_col <= '0;
          if (!put_scroll) begin
            cur_row <= cur_row + 1'b1;
          end
        end else begin
          cur_col <= cur_col + 1'b1;
        end
      end
      if (bs_en) begin
        cur_col <= cur_col - 1'b1;
      end
      if (nl_en) begin
        cur_col <= '0;
        if (cur_row != LAST_ROW) begin
          cur_row <= cur_row + 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            item_op   <= op_t'(in_op);
            item_char <= in_char;
            item_col  <= in_col_sat;
            item_row  <= in_row_sat;
            state     <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_char <= 8'd0;
          res_attr <= 8'd0;
          unique case (item_op)
            OP_WRITE_CHAR: begin
              priority if (item_char == CHAR_TAB) begin
                state <= S_TAB;
              end else if (cmd.start) begin
                state <= S_WAIT;
              end else begin
                state <= S_DONE;
              end
            end
            OP_MOVE_TO: begin
              cur_col <= item_col;
              cur_row <= item_row;
              state   <= S_DONE;
            end
            OP_CLEAR: begin
              cur_col <= '0;
              cur_row <= '0;
              state   <= S_WAIT;
            end
            OP_READ_CELL: state <= S_READ;
            default:      state <= S_DONE;
          endcase
        end
        S_TAB: begin
          priority if (!put_en) begin
            state <= S_DONE;
          end else if (cmd.start) begin
            // a wrap lands on column 0, so the tab ends after the scroll
            state <= S_WAIT;
          end else begin
            state <= S_TAB;
          end
        end
        S_WAIT: begin
          if (!store_busy) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_char <= mem_rd_data[7:0];
          res_attr <= mem_rd_data[15:8];
          state    <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free or being drained
          if (!m_tvalid || m_tready) begin
            out_loc  <= loc_wide[10:0];
            out_char <= res_char;
            out_attr <= res_attr;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {5'd0, out_attr, out_char, out_loc};

  ttcw_store #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (item_addr),
    .rd_data (mem_rd_data),
    .busy    (store_busy)
  );

endmodule

[src/ttcw_checker.sv]
// Port-level checker for the text console writer, bound to the top level.
// Depends on ttcw_pkg and tty_text_console_writer_defines.svh.
`timescale 1ns / 1ps
`include "tty_text_console_writer_defines.svh"

module ttcw_checker import ttcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  localparam int CELLS     = COLUMNS * ROWS;
  // locations above the 11-bit range wrap, so no bound applies then
  localparam bit LOC_WRAPS = (CELLS > 2048);

  // one word in flight: ready drops right after an accept
  `TTCW_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  // cursor location stays on the screen
  `TTCW_ASSERT_NOW(a_loc_on_screen, clk, rst, m_tvalid, LOC_WRAPS || (int'(m_tdata[10:0]) < CELLS))
  // a stalled result stays
  `TTCW_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  // and its word does not change
  `TTCW_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind tty_text_console_writer ttcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_ttcw_checker (.*);

[sim/tb_tty_text_console_writer.sv]
// Self-checking testbench for the text console writer: directed and random
// words, color register writes, stalls on both sides. Depends on ttcw_pkg
// and the tty_text_console_writer RTL.
`timescale 1ns / 1ps

module tb_tty_text_console_writer;
  import ttcw_pkg::*;

  localparam int COLS           = DEF_COLUMNS;
  localparam int ROWS           = DEF_ROWS;
  localparam int CELLS          = COLS * ROWS;
  // Longest legal quiet stretch is a reset fill or a scroll stacked on the
  // receiver hold-off; allow several times that.
  localparam int STALL_LIMIT    = 20000;
  localparam int RX_HOLD_CYCLES = 400;

  typedef struct packed {
    logic [10:0] cursor_loc;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_FG_COLOR;
  logic [3:0]  cfg_data = 4'h0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = 24'h0;  // operation[1:0], char_code[9:2], col[16:10], row[21:17]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;          // cursor_location[10:0], cell_char[18:11], cell_attr[26:19]

  tty_text_console_writer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Console model: screen image, cursor and colors as the block should
  // hold them after every accepted word.
  // ---------------------------------------------------------------------
  logic [15:0] screen [0:CELLS-1];
  int unsigned cur_col;
  int unsigned cur_row;
  logic [3:0]  fg_now;
  logic [3:0]  bg_now;

  console_result_t due_results[$];  // results still owed by the block, oldest first
  int          mismatches = 0;
  int          tx_idle_pct = 0;     // chance in percent that the sender skips a cycle
  int          rx_idle_pct = 0;     // chance in percent that the receiver stalls a cycle
  bit          rx_hold_req = 1'b0;
  int          rx_hold_left = 0;
  int          quiet_cycles = 0;

  function automatic logic [15:0] blank_glyph();
    return {bg_now, fg_now, CHAR_SPACE};
  endfunction

  function automatic void blank_screen();
    int i;
    for (i = 0; i < CELLS; i++) screen[i] = blank_glyph();
  endfunction

  // Wrap at the right edge; past the last row, shift everything up one row.
  function automatic void settle_cursor();
    int i;
    if (cur_col >= COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) begin
      cur_row = ROWS - 1;
      for (i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
      for (i = CELLS - COLS; i < CELLS; i++) screen[i] = blank_glyph();
    end
  endfunction

  function automatic void put_glyph(logic [7:0] ch);
    screen[cur_col + cur_row * COLS] = {bg_now, fg_now, ch};
    cur_col++;
    settle_cursor();
  endfunction

  // Apply one word to the model and return the result the block owes for it.
  function automatic console_result_t console_step(op_t op, logic [7:0] ch,
                                                   logic [6:0] col_in, logic [4:0] row_in);
    int unsigned c;
    int unsigned r;
    console_result_t res;
    c   = (col_in > COLS - 1) ? COLS - 1 : col_in;
    r   = (row_in > ROWS - 1) ? ROWS - 1 : row_in;
    res = '0;
    case (op)
      OP_WRITE_CHAR: begin
        if (ch == CHAR_NEWLINE) begin
          cur_col = 0;
          cur_row++;
          settle_cursor();
        end else if (ch == CHAR_TAB) begin
          // an aligned column writes nothing
          while ((cur_col & TAB_MASK) != 0) put_glyph(CHAR_SPACE);
        end else if (ch == CHAR_BACKSPACE) begin
          if (cur_col > 0) begin
            cur_col--;
            screen[cur_col + cur_row * COLS] = blank_glyph();
          end
        end else begin
          put_glyph(ch);
        end
      end
      OP_MOVE_TO: begin
        cur_col = c;
        cur_row = r;
      end
      OP_CLEAR: begin
        cur_col = 0;
        cur_row = 0;
        blank_screen();
      end
      OP_READ_CELL: begin
        res.cell_char = screen[c + r * COLS][7:0];
        res.cell_attr = screen[c + r * COLS][15:8];
      end
      default: ;
    endcase
    res.cursor_loc = 11'(cur_col + cur_row * COLS);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Result side: check every accepted word against the oldest expectation,
  // and drive m_tready from the current stall mode or a long hold-off.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unrequested result, cursor_location", m_tdata[10:0], -1);
        end else begin
          console_result_t want;
          want = due_results.pop_front();
          if (m_tdata[10:0] !== want.cursor_loc)
            report_mismatch("cursor_location", m_tdata[10:0], want.cursor_loc);
          if (m_tdata[18:11] !== want.cell_char)
            report_mismatch("cell_char", m_tdata[18:11], want.cell_char);
          if (m_tdata[26:19] !== want.cell_attr)
            report_mismatch("cell_attr", m_tdata[26:19], want.cell_attr);
        end
      end
      if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left != 0) begin
        m_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one word, hold it until accepted, then log its expected result.
  // Valid stays high into the next word unless an idle cycle is drawn.
  task automatic send_word(input op_t op, input logic [7:0] ch,
                           input logic [6:0] col_in, input logic [4:0] row_in);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, row_in, col_in, ch, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due_results.push_back(console_step(op, ch, col_in, row_in));
  endtask

  task automatic type_char(input logic [7:0] ch);
    send_word(OP_WRITE_CHAR, ch, 7'd0, 5'd0);
  endtask

  // Drop valid and wait until the block owes nothing, plus a short settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both color registers while the block is idle.
  task automatic set_colors(input logic [3:0] fg_val, input logic [3:0] bg_val);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FG_COLOR;
    cfg_data  <= fg_val;
    @(posedge clk);
    fg_now     = fg_val;
    cfg_index <= REG_BG_COLOR;
    cfg_data  <= bg_val;
    @(posedge clk);
    bg_now  = bg_val;
    cfg_we <= 1'b0;
  endtask

  // Mostly text with control bytes mixed in, some moves and reads, rare clears.
  task automatic send_random_word();
    int pick;
    logic [7:0] ch;
    pick = $urandom_range(99);
    if (pick < 60) begin
      case ($urandom_range(9))
        0:       ch = CHAR_NEWLINE;
        1:       ch = CHAR_TAB;
        2:       ch = CHAR_BACKSPACE;
        3:       ch = 8'($urandom_range(255));
        default: ch = 8'($urandom_range(126, 32));
      endcase
      send_word(OP_WRITE_CHAR, ch, 7'($urandom_range(127)), 5'($urandom_range(31)));
    end else if (pick < 75) begin
      send_word(OP_MOVE_TO, 8'($urandom_range(255)), 7'($urandom_range(127)),
                5'($urandom_range(31)));
    end else if (pick < 96) begin
      send_word(OP_READ_CELL, 8'($urandom_range(255)), 7'($urandom_range(127)),
                5'($urandom_range(31)));
    end else begin
      send_word(OP_CLEAR, 8'($urandom_range(255)), 7'($urandom_range(127)),
                5'($urandom_range(31)));
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Screen after reset: spaces in the reset attribute everywhere.
  task automatic test_reset_contents();
    send_word(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_word(OP_READ_CELL, 8'hFF, 7'd79, 5'd24);
    send_word(OP_READ_CELL, 8'h00, 7'd127, 5'd31);
    send_word(OP_READ_CELL, 8'h00, 7'd40, 5'd12);
  endtask

  // Each control byte, wrap, scroll and coordinate saturation.
  task automatic test_char_handling();
    type_char(8'h41);
    type_char(8'h00);
    type_char(8'hFF);
    type_char(CHAR_TAB);        // column 3 -> 8
    type_char(CHAR_TAB);        // already aligned, nothing written
    type_char(CHAR_BACKSPACE);  // erase column 7
    send_word(OP_MOVE_TO, 8'h00, 7'd0, 5'd3);
    type_char(CHAR_BACKSPACE);  // column 0: no effect
    type_char(CHAR_NEWLINE);
    send_word(OP_MOVE_TO, 8'hFF, 7'd127, 5'd31);  // saturates to the last cell
    type_char(8'h5A);           // wrap off the last cell scrolls
    send_word(OP_MOVE_TO, 8'h00, 7'd78, 5'd24);
    type_char(CHAR_NEWLINE);    // newline on the last row scrolls
    send_word(OP_MOVE_TO, 8'h00, 7'd77, 5'd24);
    type_char(CHAR_TAB);        // tab that wraps and scrolls
    send_word(OP_MOVE_TO, 8'h00, 7'd72, 5'd24);
    type_char(CHAR_TAB);        // aligned on the last row, no scroll
    send_word(OP_READ_CELL, 8'h00, 7'd79, 5'd21);
    send_word(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_word(OP_READ_CELL, 8'h00, 7'd7, 5'd0);
    send_word(OP_READ_CELL, 8'h00, 7'd127, 5'd31);
    send_word(OP_CLEAR, 8'hFF, 7'd127, 5'd31);
    send_word(OP_READ_CELL, 8'h00, 7'd5, 5'd5);
  endtask

  // Colors at both extremes and a random pair; attributes read back.
  task automatic test_color_registers();
    set_colors(4'h0, 4'h0);
    type_char(8'h61);
    type_char(CHAR_BACKSPACE);
    type_char(8'h62);
    send_word(OP_READ_CELL, 8'h00, 7'd0, 5'd0);
    set_colors(4'hF, 4'hF);
    send_word(OP_MOVE_TO, 8'h00, 7'd79, 5'd24);
    type_char(8'h63);           // scroll blanks the bottom row in the new colors
    send_word(OP_READ_CELL, 8'h00, 7'd79, 5'd23);
    send_word(OP_READ_CELL, 8'h00, 7'd10, 5'd24);
    set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
    send_word(OP_CLEAR, 8'h00, 7'd0, 5'd0);
    send_word(OP_READ_CELL, 8'h00, 7'd33, 5'd17);
  endtask

  // Receiver holds off while words keep coming, so the input side stalls.
  task automatic test_result_backpressure();
    int i;
    drain_results();
    rx_hold_req = 1'b1;
    for (i = 0; i < 16; i++) send_random_word();
    drain_results();
  endtask

  // Sender pauses until every owed result is in, then resumes.
  task automatic test_sender_pause();
    int i;
    for (i = 0; i < 6; i++) send_random_word();
    drain_results();
    for (i = 0; i < 6; i++) send_random_word();
  endtask

  task automatic test_random_traffic(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_random_word();
      if (i % 25 == 24)
        set_colors(4'($urandom_range(15)), 4'($urandom_range(15)));
    end
  endtask

  initial begin
    fg_now  = RESET_FG;
    bg_now  = RESET_BG;
    cur_col = 0;
    cur_row = 0;
    blank_screen();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 35;
    rx_idle_pct = 71;
    test_reset_contents();
    test_char_handling();
    test_color_registers();
    test_random_traffic(25);

    drain_results();
    tx_idle_pct = 71;
    rx_idle_pct = 35;
    test_sender_pause();
    test_random_traffic(20);

    drain_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_result_backpressure();
    test_random_traffic(20);
    set_colors(4'hF, 4'h0);
    test_random_traffic(10);

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
